@@ rtl/ivrp_pkg.sv @@
// Package for the indirect video RAM port with fill.
// Holds widths, register numbers, command codes and the state type.
// No dependencies.
package ivrp_pkg;

    localparam int VRAM_ADDR_BITS_DEF = 16;
    localparam int REGISTER_COUNT_DEF = 37;
    localparam int MAX_FILL_BLOCK_DEF = 255;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int SEL_W   = 6;
    localparam int UADDR_W = 16;

    localparam logic [SEL_W-1:0] REG_ADDR_HI = 6'd18;
    localparam logic [SEL_W-1:0] REG_ADDR_LO = 6'd19;
    localparam logic [SEL_W-1:0] REG_MODE    = 6'd24;
    localparam logic [SEL_W-1:0] REG_COUNT   = 6'd30;
    localparam logic [SEL_W-1:0] REG_DATA    = 6'd31;

    localparam int MODE_COPY_POS = 7;

    localparam logic [BYTE_W-1:0] STATUS_READY = 8'h80;
    localparam logic [BYTE_W-1:0] UNIMPL_READ  = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_ADDR   = 2'd0,
        CMD_RD_STATUS = 2'd1,
        CMD_WR_DATA   = 2'd2,
        CMD_RD_DATA   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [SEL_W-1:0]  addr;
        logic [BYTE_W-1:0] wdata;
    } t_reg_req;

endpackage

@@ rtl/ivrp_if.sv @@
// Handshake interfaces for the input and result channels.
// Depends on ivrp_pkg.
interface ivrp_in_if import ivrp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] bus_value;

    modport source (output valid, output command, output bus_value, input ready);
    modport sink   (input valid, input command, input bus_value, output ready);
endinterface

interface ivrp_out_if import ivrp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

@@ rtl/ivrp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ivrp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

@@ rtl/ivrp_regs.sv @@
// Internal register file: RAM plus per-entry valid bits so entries read zero after reset.
// Depends on ivrp_pkg and ivrp_ram.
module ivrp_regs import ivrp_pkg::*; #(
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_reg_req          i_req,
    output logic [BYTE_W-1:0] o_rdata
);

    localparam int RIDX_W = $clog2(REGISTER_COUNT);

    logic [REGISTER_COUNT-1:0] r_valid;
    logic                      r_rvalid;
    logic [RIDX_W-1:0]         w_idx;
    logic [BYTE_W-1:0]         w_q;

    assign w_idx = i_req.addr[RIDX_W-1:0];

    ivrp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (REGISTER_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (w_idx),
        .i_wdata (i_req.wdata),
        .i_re    (i_req.re),
        .i_raddr (w_idx),
        .o_rdata (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[w_idx] <= 1'b1;
            end
            if (i_req.re) begin
                r_rvalid <= r_valid[w_idx];
            end
        end
    end

    assign o_rdata = r_rvalid ? w_q : '0;

endmodule

@@ rtl/indirect_video_ram_port_with_fill.sv @@
// Indirect video RAM port with block fill: address port, register file, video memory.
// Output: address, status and data-port writes give their item in the cycle after accept;
// data-port reads register the register-file/video RAM read first, then the item. Throughput:
// 1 item per cycle when the output is free; a read, or a fill of N bytes (one video RAM write
// per cycle), takes no new item until done. Reset: synchronous, active low; registers read zero
// after reset through valid bits, video memory is undefined until written and is not cleared.
module indirect_video_ram_port_with_fill import ivrp_pkg::*; #(
    parameter int VRAM_ADDR_BITS = VRAM_ADDR_BITS_DEF,
    parameter int REGISTER_COUNT = REGISTER_COUNT_DEF,
    parameter int MAX_FILL_BLOCK = MAX_FILL_BLOCK_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ivrp_in_if.sink    i_in,
    ivrp_out_if.source o_out
);

    localparam logic [BYTE_W-1:0] FILL_MAX = BYTE_W'(MAX_FILL_BLOCK);
    localparam logic [SEL_W:0]    SEL_LIM  = (SEL_W+1)'(REGISTER_COUNT);

    t_state              r_state, n_state;
    logic [SEL_W-1:0]    r_sel, n_sel;
    logic [UADDR_W-1:0]  r_addr, n_addr;
    logic                r_copy, n_copy;
    logic [BYTE_W-1:0]   r_data, n_data;
    logic [BYTE_W-1:0]   r_cnt, n_cnt;
    logic                r_ov, n_ov;
    logic [BYTE_W-1:0]   r_od, n_od;

    logic                w_accept;
    logic                w_slot_free;
    t_cmd                w_cmd;
    logic [BYTE_W-1:0]   w_bus;
    logic                w_sel_ok;
    logic [BYTE_W-1:0]   w_fill_len;
    logic                w_fill_start;
    logic [UADDR_W-1:0]  w_addr_inc;
    logic [BYTE_W-1:0]   w_rd_result;
    logic                w_in_ready;

    t_reg_req            w_reg_req;
    logic [BYTE_W-1:0]   w_reg_q;
    logic                w_vwe;
    logic                w_vre;
    logic [BYTE_W-1:0]   w_vwdata;
    logic [BYTE_W-1:0]   w_vq;

    assign w_slot_free  = !r_ov || o_out.ready;
    assign w_accept     = i_in.valid && w_in_ready;
    assign w_cmd        = t_cmd'(i_in.command);
    assign w_bus        = i_in.bus_value;
    assign w_sel_ok     = {1'b0, r_sel} < SEL_LIM;
    assign w_fill_len   = (w_bus > FILL_MAX) ? FILL_MAX : w_bus;
    assign w_fill_start = (w_cmd == CMD_WR_DATA) && w_sel_ok && (r_sel == REG_COUNT)
                          && !r_copy && (w_fill_len != '0);
    assign w_addr_inc   = r_addr + UADDR_W'(1);

    ivrp_regs #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_reg_req),
        .o_rdata (w_reg_q)
    );

    ivrp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (2 ** VRAM_ADDR_BITS)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (r_addr[VRAM_ADDR_BITS-1:0]),
        .i_wdata (w_vwdata),
        .i_re    (w_vre),
        .i_raddr (r_addr[VRAM_ADDR_BITS-1:0]),
        .o_rdata (w_vq)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_cmd == CMD_RD_DATA)) begin
                    n_state = ST_READ;
                end else if (w_accept && w_fill_start) begin
                    n_state = ST_FILL;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_FILL: begin
                if (r_cnt == BYTE_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready      = 1'b0;
        w_reg_req.we    = 1'b0;
        w_reg_req.re    = 1'b0;
        w_reg_req.addr  = r_sel;
        w_reg_req.wdata = w_bus;
        w_vwe           = 1'b0;
        w_vre           = 1'b0;
        w_vwdata        = w_bus;
        case (r_state)
            ST_IDLE: begin
                w_in_ready   = w_slot_free;
                w_reg_req.we = i_in.valid && w_slot_free && (w_cmd == CMD_WR_DATA) && w_sel_ok;
                w_reg_req.re = i_in.valid && w_slot_free && (w_cmd == CMD_RD_DATA);
                w_vre        = i_in.valid && w_slot_free && (w_cmd == CMD_RD_DATA);
                w_vwe        = i_in.valid && w_slot_free && (w_cmd == CMD_WR_DATA)
                               && w_sel_ok && (r_sel == REG_DATA);
            end
            ST_FILL: begin
                w_vwe    = 1'b1;
                w_vwdata = r_data;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (!w_sel_ok) begin
            w_rd_result = UNIMPL_READ;
        end else begin
            case (r_sel)
                REG_ADDR_HI: w_rd_result = r_addr[UADDR_W-1:BYTE_W];
                REG_ADDR_LO: w_rd_result = r_addr[BYTE_W-1:0];
                REG_DATA:    w_rd_result = w_vq;
                default:     w_rd_result = w_reg_q;
            endcase
        end
    end

    always_comb begin
        n_sel  = r_sel;
        n_addr = r_addr;
        n_copy = r_copy;
        n_data = r_data;
        n_cnt  = r_cnt;
        n_ov   = r_ov && !o_out.ready;
        n_od   = r_od;
        if (w_accept) begin
            case (w_cmd)
                CMD_WR_ADDR: begin
                    n_sel = w_bus[SEL_W-1:0];
                    n_ov  = 1'b1;
                    n_od  = '0;
                end
                CMD_RD_STATUS: begin
                    n_ov = 1'b1;
                    n_od = STATUS_READY;
                end
                CMD_WR_DATA: begin
                    n_ov = 1'b1;
                    n_od = '0;
                    if (w_sel_ok) begin
                        case (r_sel)
                            REG_ADDR_HI: n_addr[UADDR_W-1:BYTE_W] = w_bus;
                            REG_ADDR_LO: n_addr[BYTE_W-1:0] = w_bus;
                            REG_MODE:    n_copy = w_bus[MODE_COPY_POS];
                            REG_DATA: begin
                                n_data = w_bus;
                                n_addr = w_addr_inc;
                            end
                            REG_COUNT: begin
                                if (w_fill_start) begin
                                    n_cnt = w_fill_len;
                                end
                            end
                            default: begin
                                n_cnt = r_cnt;
                            end
                        endcase
                    end
                end
                default: begin
                    n_od = r_od;
                end
            endcase
        end
        if (r_state == ST_READ) begin
            n_ov = 1'b1;
            n_od = w_rd_result;
            if (w_sel_ok && (r_sel == REG_DATA)) begin
                n_data = w_vq;
                n_addr = w_addr_inc;
            end
        end
        if (r_state == ST_FILL) begin
            n_addr = w_addr_inc;
            n_cnt  = r_cnt - BYTE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel   <= '0;
            r_addr  <= '0;
            r_copy  <= 1'b0;
            r_data  <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_addr  <= n_addr;
            r_copy  <= n_copy;
            r_data  <= n_data;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_od <= n_od;
    end

    assign i_in.ready      = w_in_ready;
    assign o_out.valid     = r_ov;
    assign o_out.read_data = r_od;

`ifndef NO_ASSERTIONS
    a_fill_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> !i_in.ready)
        else $error("input taken during fill");

    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) |-> (r_cnt != '0))
        else $error("fill running with zero count");

    a_read_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == CMD_RD_DATA)) |=> (r_state == ST_READ))
        else $error("data read did not start");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> r_ov)
        else $error("data read gave no item");
`endif

endmodule

@@ tb/sv/tb_indirect_video_ram_port_with_fill.sv @@
`timescale 1ns / 100ps
// Testbench for indirect_video_ram_port_with_fill: a directed table, then random port sequences.
// Predicts each read_data item in SystemVerilog or takes it from the directed table, and checks the items in order.
// Depends on ivrp_pkg, ivrp_in_if, ivrp_out_if and the block itself.
module tb_indirect_video_ram_port_with_fill;
    import ivrp_pkg::*;

    localparam int VRAM_BITS    = VRAM_ADDR_BITS_DEF;
    localparam int REG_TOTAL    = REGISTER_COUNT_DEF;
    localparam int FILL_MAX     = MAX_FILL_BLOCK_DEF;
    localparam int VRAM_DEPTH   = 1 << VRAM_BITS;
    localparam int RANDOM_ITEMS = 1850;
    localparam int PAUSE_AT     = 1100;
    localparam int HOLD_AT      = 500;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 5000000;

    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] val;
        logic              fixed;
        logic [BYTE_W-1:0] result;
    } t_dir_row;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_BURSTY
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    ivrp_in_if  in_ch ();
    ivrp_out_if out_ch ();

    indirect_video_ram_port_with_fill #(
        .VRAM_ADDR_BITS(VRAM_BITS),
        .REGISTER_COUNT(REG_TOTAL),
        .MAX_FILL_BLOCK(FILL_MAX)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    logic [SEL_W-1:0]  sel_shadow;
    logic [BYTE_W-1:0] reg_shadow [REG_TOTAL];
    logic [BYTE_W-1:0] vram_shadow [VRAM_DEPTH];
    bit                vram_written [VRAM_DEPTH];
    logic [BYTE_W-1:0] expected_read_data [$];

    int error_count  = 0;
    int results_seen = 0;
    int sent_count   = 0;
    int burst_left   = 0;
    int cycle_count  = 0;

    t_dir_row directed_items [28] = '{
        '{CMD_RD_STATUS, 8'h00, 1'b1, STATUS_READY},
        '{CMD_RD_DATA,   8'hFF, 1'b1, 8'h00},
        '{CMD_WR_ADDR,   8'hFF, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'h55, 1'b1, 8'h00},
        '{CMD_WR_ADDR,   8'h25, 1'b1, 8'h00},
        '{CMD_RD_DATA,   8'h00, 1'b1, UNIMPL_READ},
        '{CMD_WR_ADDR,   8'h24, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'hFF, 1'b1, 8'h00},
        '{CMD_RD_DATA,   8'h00, 1'b1, 8'hFF},
        '{CMD_WR_ADDR,   8'hD2, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'hFF, 1'b1, 8'h00},
        '{CMD_WR_ADDR,   8'h13, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'hFE, 1'b1, 8'h00},
        '{CMD_WR_ADDR,   8'h1F, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'hAA, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'h00, 1'b1, 8'h00},
        '{CMD_WR_ADDR,   8'h1E, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'h03, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'h00, 1'b1, 8'h00},
        '{CMD_WR_ADDR,   8'h18, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'h80, 1'b1, 8'h00},
        '{CMD_WR_ADDR,   8'h1E, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'h05, 1'b1, 8'h00},
        '{CMD_RD_DATA,   8'h00, 1'b0, 8'h00},
        '{CMD_WR_ADDR,   8'h13, 1'b1, 8'h00},
        '{CMD_WR_DATA,   8'h01, 1'b1, 8'h00},
        '{CMD_WR_ADDR,   8'h1F, 1'b1, 8'h00},
        '{CMD_RD_DATA,   8'h00, 1'b0, 8'h00}
    };

    function automatic logic [UADDR_W-1:0] update_addr();
        return {reg_shadow[REG_ADDR_HI], reg_shadow[REG_ADDR_LO]};
    endfunction

    function automatic int vram_index();
        return int'(update_addr()) & (VRAM_DEPTH - 1);
    endfunction

    function automatic void advance_update_addr();
        logic [UADDR_W-1:0] next_addr;
        next_addr = update_addr() + 16'd1;
        reg_shadow[REG_ADDR_HI] = next_addr[15:8];
        reg_shadow[REG_ADDR_LO] = next_addr[7:0];
    endfunction

    function automatic void store_vram(logic [BYTE_W-1:0] v);
        vram_shadow[vram_index()] = v;
        vram_written[vram_index()] = 1'b1;
        advance_update_addr();
    endfunction

    function automatic logic [BYTE_W-1:0] predict_read_data(t_cmd cmd, logic [BYTE_W-1:0] val);
        logic [BYTE_W-1:0] res;
        int                fill_n;
        res = '0;
        case (cmd)
            CMD_WR_ADDR: sel_shadow = val[SEL_W-1:0];
            CMD_RD_STATUS: res = STATUS_READY;
            CMD_WR_DATA: begin
                if (sel_shadow < REG_TOTAL) begin
                    reg_shadow[sel_shadow] = val;
                    if (sel_shadow == REG_DATA) begin
                        store_vram(val);
                    end else if (sel_shadow == REG_COUNT &&
                                 !reg_shadow[REG_MODE][MODE_COPY_POS]) begin
                        fill_n = (int'(val) > FILL_MAX) ? FILL_MAX : int'(val);
                        for (int i = 0; i < fill_n; i++) store_vram(reg_shadow[REG_DATA]);
                    end
                end
            end
            default: begin
                if (sel_shadow >= REG_TOTAL) begin
                    res = UNIMPL_READ;
                end else if (sel_shadow == REG_DATA) begin
                    res = vram_shadow[vram_index()];
                    advance_update_addr();
                    reg_shadow[REG_DATA] = res;
                end else begin
                    res = reg_shadow[sel_shadow];
                end
            end
        endcase
        return res;
    endfunction

    task automatic send_item(input t_cmd cmd, input logic [BYTE_W-1:0] val,
                             input bit fixed = 1'b0, input logic [BYTE_W-1:0] fixed_val = 8'h00);
        logic [BYTE_W-1:0] predicted;
        // never read video memory that was not written
        if (cmd == CMD_RD_DATA && sel_shadow == REG_DATA && !vram_written[vram_index()])
            cmd = CMD_RD_STATUS;
        in_ch.command   <= cmd;
        in_ch.bus_value <= val;
        in_ch.valid     <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = predict_read_data(cmd, val);
        expected_read_data.push_back(fixed ? fixed_val : predicted);
        sent_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic select_reg(input logic [SEL_W-1:0] r);
        logic [BYTE_W-1:0] v;
        v = 8'($urandom);
        v[SEL_W-1:0] = r;
        send_item(CMD_WR_ADDR, v);
    endtask

    task automatic set_update_addr(input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo);
        select_reg(REG_ADDR_HI);
        send_item(CMD_WR_DATA, hi);
        select_reg(REG_ADDR_LO);
        send_item(CMD_WR_DATA, lo);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_rx_mode mode;
        int       seg_left;
        int       hold_left;
        bit       hold_done;
        mode      = RX_ALWAYS;
        seg_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (seg_left == 0) begin
                mode     = t_rx_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(10, 80);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_ALWAYS: out_ch.ready <= 1'b1;
                    RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ch.ready <= (seg_left % 4 == 0);
                    default:   out_ch.ready <= (seg_left % 16 >= 3);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_read_data
        logic [BYTE_W-1:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_read_data.size() == 0) begin
                $error("read_data: expected no item, got %02h", out_ch.read_data);
                error_count++;
            end else begin
                want = expected_read_data.pop_front();
                if (out_ch.read_data !== want) begin
                    $error("read_data: expected %02h, got %02h", want, out_ch.read_data);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] v;
        t_cmd              cmd;
        int                pick;
        int                count;
        int                r;
        bit                paused;
        paused = 1'b0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.command   <= CMD_WR_ADDR;
        in_ch.bus_value <= '0;
        sel_shadow = '0;
        foreach (reg_shadow[i]) reg_shadow[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_items[i])
            send_item(directed_items[i].cmd, directed_items[i].val,
                      directed_items[i].fixed, directed_items[i].result);

        while (sent_count < $size(directed_items) + RANDOM_ITEMS) begin
            if (!paused && sent_count >= PAUSE_AT) begin
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (expected_read_data.size() != 0);
            end
            pick = $urandom_range(0, 99);
            hi = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            lo = 8'($urandom);
            if (pick < 30) begin
                count = $urandom_range(1, 12);
                set_update_addr(hi, lo);
                select_reg(REG_DATA);
                repeat (count) send_item(CMD_WR_DATA, 8'($urandom));
                set_update_addr(hi, lo);
                select_reg(REG_DATA);
                repeat (count)
                    send_item(($urandom_range(0, 7) == 0) ? CMD_RD_STATUS : CMD_RD_DATA,
                              8'($urandom));
            end else if (pick < 50) begin
                v = 8'($urandom);
                v[MODE_COPY_POS] = ($urandom_range(0, 3) == 0);
                select_reg(REG_MODE);
                send_item(CMD_WR_DATA, v);
                set_update_addr(hi, lo);
                select_reg(REG_DATA);
                send_item(CMD_WR_DATA, 8'($urandom));
                select_reg(REG_COUNT);
                count = ($urandom_range(0, 19) == 0) ? $urandom_range(FILL_MAX / 2, FILL_MAX)
                                                     : $urandom_range(0, 8);
                send_item(CMD_WR_DATA, 8'(count));
                set_update_addr(hi, lo);
                select_reg(REG_DATA);
                repeat ((count + 2 > 12) ? 12 : count + 2)
                    send_item(CMD_RD_DATA, 8'($urandom));
            end else if (pick < 75) begin
                r = $urandom_range(0, 63);
                select_reg(6'(r));
                v = 8'($urandom);
                if (r == REG_COUNT && $urandom_range(0, 9) != 0) v = 8'($urandom_range(0, 8));
                send_item(CMD_WR_DATA, v);
                send_item(CMD_RD_DATA, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    cmd = t_cmd'($urandom_range(0, 3));
                    v = 8'($urandom);
                    // keep most stray fills short
                    if (cmd == CMD_WR_DATA && sel_shadow == REG_COUNT &&
                        $urandom_range(0, 9) != 0)
                        v = v & 8'h07;
                    send_item(cmd, v);
                end
            end
        end

        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_read_data.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
